### hw/rtl/capture_session_ack_sequencer_core_assert.svh
// Assertion macros for the capture session sequencer.
// Used by capture_session_ack_sequencer_core; expects signals named clock and reset.
`ifndef CAPTURE_SESSION_ACK_SEQUENCER_CORE_ASSERT_SVH
`define CAPTURE_SESSION_ACK_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CSAS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define CSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/csas_pkg.sv
// Shared types and constants of the capture session sequencer.
// No dependencies; used by the channel interfaces, csas_step and the top level.
`timescale 1ns / 1ps

package csas_pkg;

   localparam int OP_W       = 3;
   localparam int LINE_W     = 10;
   localparam int REP_W      = 16;
   localparam int SEQ_W      = 32;
   localparam int TIME_W     = 32;
   localparam int DRAIN_W    = 20;
   localparam int PHASE_W    = 4;
   localparam int REC_W      = 3;
   localparam int ARM_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE          = 4'd0,
      PH_SEND_SESSION  = 4'd1,
      PH_SEND_TIMING   = 4'd2,
      PH_SEND_RAW      = 4'd3,
      PH_SEND_COMPLETE = 4'd4,
      PH_CAP_TIMING    = 4'd5,
      PH_CAP_RAW       = 4'd6,
      PH_DRAIN         = 4'd7,
      PH_WAIT          = 4'd8
   } phase_type;

   typedef enum logic [OP_W-1:0] {
      OP_START   = 3'd0,
      OP_CANCEL  = 3'd1,
      OP_ACK     = 3'd2,
      OP_SERVICE = 3'd3,
      OP_STOP    = 3'd4
   } op_type;

   typedef enum logic [REC_W-1:0] {
      REC_NONE     = 3'd0,
      REC_SESSION  = 3'd1,
      REC_TIMING   = 3'd2,
      REC_RAW      = 3'd3,
      REC_COMPLETE = 3'd4
   } rec_type;

   typedef enum logic [ARM_W-1:0] {
      ARM_NONE   = 2'd0,
      ARM_TIMING = 2'd1,
      ARM_RAW    = 2'd2
   } arm_type;

   typedef enum logic [1:0] {
      PEND_NONE    = 2'd0,
      PEND_ADVANCE = 2'd1,
      PEND_RETRY   = 2'd2
   } pend_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_START_LINE   = 3'd0,
      CSR_MAX_START_LINE   = 3'd1,
      CSR_MAX_LINE_COUNT   = 3'd2,
      CSR_MAX_REPEAT_COUNT = 3'd3,
      CSR_DRAIN_TIME_US    = 3'd4
   } csr_idx_type;

   localparam logic [LINE_W-1:0]  MIN_START_LINE_RST   = 10'd1;
   localparam logic [LINE_W-1:0]  MAX_START_LINE_RST   = 10'd312;
   localparam logic [LINE_W-1:0]  MAX_LINE_COUNT_RST   = 10'd64;
   localparam logic [REP_W-1:0]   MAX_REPEAT_COUNT_RST = 16'd16;
   localparam logic [DRAIN_W-1:0] DRAIN_TIME_US_RST    = 20'd10000;

   typedef struct packed {
      logic [LINE_W-1:0]  min_start_line;
      logic [LINE_W-1:0]  max_start_line;
      logic [LINE_W-1:0]  max_line_count;
      logic [REP_W-1:0]   max_repeat_count;
      logic [DRAIN_W-1:0] drain_time_us;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      min_start_line:   MIN_START_LINE_RST,
      max_start_line:   MAX_START_LINE_RST,
      max_line_count:   MAX_LINE_COUNT_RST,
      max_repeat_count: MAX_REPEAT_COUNT_RST,
      drain_time_us:    DRAIN_TIME_US_RST
   };

   typedef struct packed {
      phase_type          phase;
      phase_type          drained_phase;
      logic               cancel_flag;
      pend_type           pending;
      logic [LINE_W-1:0]  base_line;
      logic [LINE_W-1:0]  lines_per_cap;
      logic [REP_W-1:0]   repeat_total;
      logic [REP_W-1:0]   repeat_index;
      logic [SEQ_W-1:0]   sequence_num;
      logic [TIME_W-1:0]  drain_start;
      logic [TIME_W-1:0]  session;
   } state_type;

   localparam state_type STATE_RST = '{
      phase:         PH_IDLE,
      drained_phase: PH_IDLE,
      cancel_flag:   1'b0,
      pending:       PEND_NONE,
      base_line:     '0,
      lines_per_cap: '0,
      repeat_total:  '0,
      repeat_index:  '0,
      sequence_num:  '0,
      drain_start:   '0,
      session:       '0
   };

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [LINE_W-1:0] first_line;
      logic [LINE_W-1:0] lines_wanted;
      logic [REP_W-1:0]  repeats_wanted;
      logic              engine_blocked;
      logic [SEQ_W-1:0]  ack_sequence;
      logic              ack_retry;
      logic              link_up;
      logic              capture_done;
      logic              send_done;
      logic [TIME_W-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic              accepted;
      phase_type         phase;
      rec_type           record_started;
      arm_type           arm_command;
      logic              halt_capture;
      logic              resend;
      logic [SEQ_W-1:0]  sequence_now;
      logic [REP_W-1:0]  repeat_now;
      logic              was_cancelled;
      logic [TIME_W-1:0] session_tag;
   } rsp_type;

endpackage

### hw/rtl/csas_req_if.sv
// Event channel of the capture session sequencer: valid, ready and the event fields.
// Depends on csas_pkg for field widths.
`timescale 1ns / 1ps

interface csas_req_if;
   logic                          valid;
   logic                          ready;
   logic [csas_pkg::OP_W-1:0]     op;
   logic [csas_pkg::LINE_W-1:0]   first_line;
   logic [csas_pkg::LINE_W-1:0]   lines_wanted;
   logic [csas_pkg::REP_W-1:0]    repeats_wanted;
   logic                          engine_blocked;
   logic [csas_pkg::SEQ_W-1:0]    ack_sequence;
   logic                          ack_retry;
   logic                          link_up;
   logic                          capture_done;
   logic                          send_done;
   logic [csas_pkg::TIME_W-1:0]   now_us;

   modport source (
      output valid, op, first_line, lines_wanted, repeats_wanted, engine_blocked,
             ack_sequence, ack_retry, link_up, capture_done, send_done, now_us,
      input  ready
   );

   modport sink (
      input  valid, op, first_line, lines_wanted, repeats_wanted, engine_blocked,
             ack_sequence, ack_retry, link_up, capture_done, send_done, now_us,
      output ready
   );
endinterface

### hw/rtl/csas_rsp_if.sv
// Result channel of the capture session sequencer: valid, ready and the result fields.
// Depends on csas_pkg for field widths.
`timescale 1ns / 1ps

interface csas_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic [csas_pkg::PHASE_W-1:0]  phase;
   logic [csas_pkg::REC_W-1:0]    record_started;
   logic [csas_pkg::ARM_W-1:0]    arm_command;
   logic                          halt_capture;
   logic                          resend;
   logic [csas_pkg::SEQ_W-1:0]    sequence_now;
   logic [csas_pkg::REP_W-1:0]    repeat_now;
   logic                          was_cancelled;
   logic [csas_pkg::TIME_W-1:0]   session_tag;

   modport source (
      output valid, accepted, phase, record_started, arm_command, halt_capture,
             resend, sequence_now, repeat_now, was_cancelled, session_tag,
      input  ready
   );

   modport sink (
      input  valid, accepted, phase, record_started, arm_command, halt_capture,
             resend, sequence_now, repeat_now, was_cancelled, session_tag,
      output ready
   );
endinterface

### hw/rtl/csas_step.sv
// Next-state and result logic for one event beat of the session sequencer.
// Purely combinational; depends on csas_pkg.
`timescale 1ns / 1ps

module csas_step (
   input  csas_pkg::cfg_type   cfg,
   input  csas_pkg::state_type state_q,
   input  csas_pkg::req_type   item,
   output csas_pkg::state_type state_d,
   output csas_pkg::rsp_type   result
);

   // Effect of advancing past the drained record, from the current state.
   csas_pkg::phase_type         adv_phase;
   csas_pkg::rec_type           adv_rec;
   csas_pkg::arm_type           adv_arm;
   logic                        adv_inc;
   logic [csas_pkg::REP_W-1:0]  adv_repeat;

   always_comb begin
      adv_phase  = state_q.phase;
      adv_rec    = csas_pkg::REC_NONE;
      adv_arm    = csas_pkg::ARM_NONE;
      adv_inc    = 1'b0;
      adv_repeat = state_q.repeat_index;
      case (state_q.drained_phase)
         csas_pkg::PH_SEND_SESSION: begin
            if (state_q.cancel_flag) begin
               adv_phase = csas_pkg::PH_SEND_COMPLETE;
               adv_rec   = csas_pkg::REC_COMPLETE;
               adv_inc   = 1'b1;
            end else begin
               adv_phase = csas_pkg::PH_CAP_TIMING;
               adv_arm   = csas_pkg::ARM_TIMING;
            end
         end
         csas_pkg::PH_SEND_TIMING: begin
            if (state_q.cancel_flag) begin
               adv_phase = csas_pkg::PH_SEND_COMPLETE;
               adv_rec   = csas_pkg::REC_COMPLETE;
               adv_inc   = 1'b1;
            end else begin
               adv_repeat = {{(csas_pkg::REP_W-1){1'b0}}, 1'b1};
               adv_phase  = csas_pkg::PH_CAP_RAW;
               adv_arm    = csas_pkg::ARM_RAW;
            end
         end
         csas_pkg::PH_SEND_RAW: begin
            if (state_q.cancel_flag || state_q.repeat_index >= state_q.repeat_total) begin
               adv_phase = csas_pkg::PH_SEND_COMPLETE;
               adv_rec   = csas_pkg::REC_COMPLETE;
               adv_inc   = 1'b1;
            end else begin
               adv_repeat = state_q.repeat_index + {{(csas_pkg::REP_W-1){1'b0}}, 1'b1};
               adv_phase  = csas_pkg::PH_CAP_RAW;
               adv_arm    = csas_pkg::ARM_RAW;
            end
         end
         csas_pkg::PH_SEND_COMPLETE: begin
            adv_phase = csas_pkg::PH_IDLE;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      csas_pkg::state_type          st;
      csas_pkg::phase_type          p;
      logic                         acc;
      logic                         halt;
      logic                         resend;
      csas_pkg::rec_type            rec;
      csas_pkg::arm_type            arm;
      logic                         host_go;
      logic                         host_retry;
      logic                         start_ok;
      logic [csas_pkg::TIME_W-1:0]  elapsed;

      st         = state_q;
      p          = state_q.phase;
      acc        = 1'b0;
      halt       = 1'b0;
      resend     = 1'b0;
      rec        = csas_pkg::REC_NONE;
      arm        = csas_pkg::ARM_NONE;
      host_go    = 1'b0;
      host_retry = 1'b0;
      elapsed    = item.now_us - state_q.drain_start;
      start_ok   = (state_q.phase == csas_pkg::PH_IDLE) && !item.engine_blocked &&
                   (item.first_line >= cfg.min_start_line) &&
                   (item.first_line <= cfg.max_start_line) &&
                   (item.lines_wanted != '0) && (item.lines_wanted <= cfg.max_line_count) &&
                   (item.repeats_wanted != '0) &&
                   (item.repeats_wanted <= cfg.max_repeat_count);

      case (item.op)
         csas_pkg::OP_START: begin
            if (start_ok) begin
               st.base_line     = item.first_line;
               st.lines_per_cap = item.lines_wanted;
               st.repeat_total  = item.repeats_wanted;
               st.repeat_index  = '0;
               st.session       = item.now_us;
               st.sequence_num  = {{(csas_pkg::SEQ_W-1){1'b0}}, 1'b1};
               st.cancel_flag   = 1'b0;
               st.pending       = csas_pkg::PEND_NONE;
               st.phase         = csas_pkg::PH_SEND_SESSION;
               rec              = csas_pkg::REC_SESSION;
               acc              = 1'b1;
            end
         end
         csas_pkg::OP_CANCEL: begin
            if (state_q.phase != csas_pkg::PH_IDLE) begin
               st.cancel_flag = 1'b1;
               if (state_q.phase inside {csas_pkg::PH_CAP_TIMING, csas_pkg::PH_CAP_RAW,
                                         csas_pkg::PH_WAIT}) begin
                  halt            = (state_q.phase != csas_pkg::PH_WAIT);
                  st.sequence_num = state_q.sequence_num +
                                    {{(csas_pkg::SEQ_W-1){1'b0}}, 1'b1};
                  st.phase        = csas_pkg::PH_SEND_COMPLETE;
                  rec             = csas_pkg::REC_COMPLETE;
               end else if (state_q.phase == csas_pkg::PH_DRAIN) begin
                  st.pending = csas_pkg::PEND_ADVANCE;
               end
            end
         end
         csas_pkg::OP_ACK: begin
            if (item.ack_sequence == state_q.sequence_num &&
                state_q.drained_phase inside {csas_pkg::PH_SEND_TIMING,
                                              csas_pkg::PH_SEND_RAW}) begin
               if (state_q.phase == csas_pkg::PH_DRAIN) begin
                  st.pending = item.ack_retry ? csas_pkg::PEND_RETRY : csas_pkg::PEND_ADVANCE;
                  acc        = 1'b1;
               end else if (state_q.phase == csas_pkg::PH_WAIT) begin
                  host_go    = 1'b1;
                  host_retry = item.ack_retry;
                  acc        = 1'b1;
               end
            end
         end
         csas_pkg::OP_SERVICE: begin
            if (state_q.phase != csas_pkg::PH_IDLE) begin
               if (!item.link_up) begin
                  // link loss acts as stop
                  halt           = 1'b1;
                  st.phase       = csas_pkg::PH_IDLE;
                  st.drain_start = '0;
                  st.pending     = csas_pkg::PEND_NONE;
               end else if (state_q.phase == csas_pkg::PH_DRAIN) begin
                  if (elapsed >= {{(csas_pkg::TIME_W-csas_pkg::DRAIN_W){1'b0}},
                                  cfg.drain_time_us}) begin
                     if (state_q.drained_phase inside {csas_pkg::PH_SEND_TIMING,
                                                       csas_pkg::PH_SEND_RAW}) begin
                        st.phase = csas_pkg::PH_WAIT;
                        if (state_q.pending != csas_pkg::PEND_NONE) begin
                           st.pending = csas_pkg::PEND_NONE;
                           host_go    = 1'b1;
                           host_retry = (state_q.pending == csas_pkg::PEND_RETRY);
                        end
                     end else begin
                        host_go = 1'b1;
                     end
                  end
               end else begin
                  if (state_q.phase == csas_pkg::PH_CAP_TIMING && item.capture_done) begin
                     halt            = 1'b1;
                     st.sequence_num = state_q.sequence_num +
                                       {{(csas_pkg::SEQ_W-1){1'b0}}, 1'b1};
                     rec             = csas_pkg::REC_TIMING;
                     p               = csas_pkg::PH_SEND_TIMING;
                  end else if (state_q.phase == csas_pkg::PH_CAP_RAW && item.capture_done) begin
                     halt            = 1'b1;
                     st.sequence_num = state_q.sequence_num +
                                       {{(csas_pkg::SEQ_W-1){1'b0}}, 1'b1};
                     rec             = csas_pkg::REC_RAW;
                     p               = csas_pkg::PH_SEND_RAW;
                  end
                  st.phase = p;
                  // a record begun this beat may also finish sending in it
                  if (p inside {[csas_pkg::PH_SEND_SESSION:csas_pkg::PH_SEND_COMPLETE]} &&
                      item.send_done) begin
                     st.drained_phase = p;
                     st.drain_start   = item.now_us;
                     st.phase         = csas_pkg::PH_DRAIN;
                  end
               end
            end
         end
         csas_pkg::OP_STOP: begin
            halt           = 1'b1;
            st.phase       = csas_pkg::PH_IDLE;
            st.drain_start = '0;
            st.pending     = csas_pkg::PEND_NONE;
         end
         default: begin
         end
      endcase

      if (host_go) begin
         if (host_retry) begin
            resend   = 1'b1;
            st.phase = state_q.drained_phase;
         end else begin
            st.phase        = adv_phase;
            rec             = adv_rec;
            arm             = adv_arm;
            st.repeat_index = adv_repeat;
            st.sequence_num = state_q.sequence_num + {{(csas_pkg::SEQ_W-1){1'b0}}, adv_inc};
         end
      end

      state_d               = st;
      result.accepted       = acc;
      result.phase          = st.phase;
      result.record_started = rec;
      result.arm_command    = arm;
      result.halt_capture   = halt;
      result.resend         = resend;
      result.sequence_now   = st.sequence_num;
      result.repeat_now     = st.repeat_index;
      result.was_cancelled  = st.cancel_flag;
      result.session_tag    = st.session;
   end

endmodule

### hw/rtl/capture_session_ack_sequencer_core.sv
// Top level of the capture session sequencer: config registers, state, result register.
// Depends on csas_pkg, csas_req_if, csas_rsp_if, csas_step and the assertion header.
`timescale 1ns / 1ps
//
//  channel   dir  handshake            beat carries
//  --------  ---  -------------------  -----------------------------------------
//  req_chan  in   valid/ready          one event (start/cancel/ack/service/stop)
//  rsp_chan  out  valid/ready          one result per event, phase and counters
//  csr_*     in   csr_we, no wait      register index and write data
//
//  One event per cycle. An accepted beat updates the session state at the same
//  edge and its result lands in the output register, valid from the next cycle.
//  req_chan.ready is high while the output register is empty or being taken, so
//  a new beat enters in the cycle its predecessor's result leaves.
//  Reset is synchronous, active high: state, config and result valid take defaults,
//  result data is not reset, and no beat is accepted while reset is high.
//  A stalled rsp_chan holds its beat and stops intake; no work is lost.

`include "capture_session_ack_sequencer_core_assert.svh"

module capture_session_ack_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [csas_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csas_pkg::CSR_DATA_W-1:0]   csr_wdata,
   csas_req_if.sink                          req_chan,
   csas_rsp_if.source                        rsp_chan
);

   csas_pkg::cfg_type   cfg_ff, cfg_in;
   csas_pkg::state_type state_ff, state_in;
   csas_pkg::rsp_type   rsp_ff, rsp_in;
   csas_pkg::req_type   item;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   // ---- configuration writes; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            csas_pkg::CSR_MIN_START_LINE:
               cfg_in.min_start_line = csr_wdata[csas_pkg::LINE_W-1:0];
            csas_pkg::CSR_MAX_START_LINE:
               cfg_in.max_start_line = csr_wdata[csas_pkg::LINE_W-1:0];
            csas_pkg::CSR_MAX_LINE_COUNT:
               cfg_in.max_line_count = csr_wdata[csas_pkg::LINE_W-1:0];
            csas_pkg::CSR_MAX_REPEAT_COUNT:
               cfg_in.max_repeat_count = csr_wdata[csas_pkg::REP_W-1:0];
            csas_pkg::CSR_DRAIN_TIME_US:
               cfg_in.drain_time_us = csr_wdata[csas_pkg::DRAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= csas_pkg::CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- intake: ready while the result register is free or draining this cycle
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign item.op             = req_chan.op;
   assign item.first_line     = req_chan.first_line;
   assign item.lines_wanted   = req_chan.lines_wanted;
   assign item.repeats_wanted = req_chan.repeats_wanted;
   assign item.engine_blocked = req_chan.engine_blocked;
   assign item.ack_sequence   = req_chan.ack_sequence;
   assign item.ack_retry      = req_chan.ack_retry;
   assign item.link_up        = req_chan.link_up;
   assign item.capture_done   = req_chan.capture_done;
   assign item.send_done      = req_chan.send_done;
   assign item.now_us         = req_chan.now_us;

   // ---- per-event decision logic
   csas_step u_step (
      .cfg     (cfg_ff),
      .state_q (state_ff),
      .item    (item),
      .state_d (state_in),
      .result  (rsp_in)
   );

   // ---- session state, committed only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csas_pkg::STATE_RST;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // ---- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accepted       = rsp_ff.accepted;
   assign rsp_chan.phase          = rsp_ff.phase;
   assign rsp_chan.record_started = rsp_ff.record_started;
   assign rsp_chan.arm_command    = rsp_ff.arm_command;
   assign rsp_chan.halt_capture   = rsp_ff.halt_capture;
   assign rsp_chan.resend         = rsp_ff.resend;
   assign rsp_chan.sequence_now   = rsp_ff.sequence_now;
   assign rsp_chan.repeat_now     = rsp_ff.repeat_now;
   assign rsp_chan.was_cancelled  = rsp_ff.was_cancelled;
   assign rsp_chan.session_tag    = rsp_ff.session_tag;

   // ---- checks
   `CSAS_ASSERT_SAME(a_stall_blocks_intake, rsp_valid_ff && !rsp_chan.ready, !req_chan.ready, "intake open while result stalled")
   `CSAS_ASSERT_NEXT(a_accept_gives_result, accept, rsp_valid_ff, "accepted beat left no result")
   `CSAS_ASSERT_NEXT(a_stop_goes_idle, accept && req_chan.op == csas_pkg::OP_STOP, rsp_ff.phase == csas_pkg::PH_IDLE && rsp_ff.halt_capture && state_ff.pending == csas_pkg::PEND_NONE, "stop did not return to idle")
   `CSAS_ASSERT_NEXT(a_start_opens_session, accept && rsp_in.accepted && req_chan.op == csas_pkg::OP_START, rsp_ff.sequence_now == 32'd1 && rsp_ff.phase == csas_pkg::PH_SEND_SESSION && rsp_ff.record_started == csas_pkg::REC_SESSION, "start did not open a session record")

endmodule

### verif/tb_capture_session_ack_sequencer_core.sv
// Self-checking bench for capture_session_ack_sequencer_core: event beats in, one report beat out per event.
// Needs csas_pkg, csas_req_if, csas_rsp_if and the core; keeps its own session state to predict.
`timescale 1ns / 1ps

module tb_capture_session_ack_sequencer_core;

   // Unnamed op codes; the core must leave its state alone for these.
   localparam logic [csas_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [csas_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam int CYCLE_LIMIT = 200000;  // watchdog bound on the whole run
   localparam int HOLD_CYCLES = 150;     // long receiver hold-off, fills the output register
   localparam int SETTLE      = 8;       // spare edges at the end, after the last report

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [csas_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [csas_pkg::CSR_DATA_W-1:0] csr_wdata;

   csas_req_if req_chan ();
   csas_rsp_if rsp_chan ();

   capture_session_ack_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Session shadow: our own copy of state and limits, advanced once per
   // accepted event beat. Reports it produces queue up in report_q.
   // ---------------------------------------------------------------------
   csas_pkg::state_type sess;
   csas_pkg::cfg_type   limits;
   csas_pkg::rsp_type   outcome;
   csas_pkg::rsp_type   report_q[$];
   csas_pkg::rsp_type   due;

   int tx_idle_pct;
   int rx_idle_pct;
   int hold_asked;
   int hold_served;
   int hold_left;
   int cycle_count;
   int faults;
   int events_sent;
   int results_checked;
   int sessions_opened;
   int resends_seen;

   // Every record begin bumps the sequence number.
   function automatic void open_record(input csas_pkg::rec_type kind,
                                       input csas_pkg::phase_type nxt);
      sess.sequence_num   = sess.sequence_num + 1;
      outcome.record_started = kind;
      sess.phase          = nxt;
   endfunction

   function automatic void prime_capture(input bit raw);
      if (raw) begin
         outcome.arm_command = csas_pkg::ARM_RAW;
         sess.phase          = csas_pkg::PH_CAP_RAW;
      end else begin
         outcome.arm_command = csas_pkg::ARM_TIMING;
         sess.phase          = csas_pkg::PH_CAP_TIMING;
      end
   endfunction

   // Next step once a sent record is done with (drain over, or host said go).
   function automatic void close_record(input csas_pkg::phase_type done);
      case (done)
         csas_pkg::PH_SEND_SESSION: begin
            if (sess.cancel_flag) open_record(csas_pkg::REC_COMPLETE, csas_pkg::PH_SEND_COMPLETE);
            else prime_capture(1'b0);
         end
         csas_pkg::PH_SEND_TIMING: begin
            if (sess.cancel_flag) open_record(csas_pkg::REC_COMPLETE, csas_pkg::PH_SEND_COMPLETE);
            else begin
               sess.repeat_index = csas_pkg::REP_W'(1);
               prime_capture(1'b1);
            end
         end
         csas_pkg::PH_SEND_RAW: begin
            if (sess.cancel_flag || sess.repeat_index >= sess.repeat_total)
               open_record(csas_pkg::REC_COMPLETE, csas_pkg::PH_SEND_COMPLETE);
            else begin
               sess.repeat_index = csas_pkg::REP_W'(sess.repeat_index + 1);
               prime_capture(1'b1);
            end
         end
         csas_pkg::PH_SEND_COMPLETE: sess.phase = csas_pkg::PH_IDLE;
         default: ;
      endcase
   endfunction

   function automatic void host_reply(input bit retry);
      if (retry) begin
         outcome.resend = 1'b1;
         sess.phase     = sess.drained_phase;
         resends_seen++;
      end else
         close_record(sess.drained_phase);
   endfunction

   function automatic void halt_session();
      outcome.halt_capture = 1'b1;
      sess.phase           = csas_pkg::PH_IDLE;
      sess.drain_start     = '0;
      sess.pending         = csas_pkg::PEND_NONE;
   endfunction

   function automatic csas_pkg::rsp_type apply_event(input csas_pkg::req_type ev);
      logic [csas_pkg::TIME_W-1:0] waited;
      bit acked_record;
      bit retry_now;
      outcome = '0;
      acked_record = (sess.drained_phase == csas_pkg::PH_SEND_TIMING ||
                      sess.drained_phase == csas_pkg::PH_SEND_RAW);
      case (ev.op)
         csas_pkg::OP_START: begin
            if (sess.phase == csas_pkg::PH_IDLE && !ev.engine_blocked &&
                ev.first_line >= limits.min_start_line &&
                ev.first_line <= limits.max_start_line &&
                ev.lines_wanted != 0 && ev.lines_wanted <= limits.max_line_count &&
                ev.repeats_wanted != 0 && ev.repeats_wanted <= limits.max_repeat_count) begin
               sess.base_line     = ev.first_line;
               sess.lines_per_cap = ev.lines_wanted;
               sess.repeat_total  = ev.repeats_wanted;
               sess.repeat_index  = '0;
               sess.session       = ev.now_us;
               sess.sequence_num  = '0;
               sess.cancel_flag   = 1'b0;
               sess.pending       = csas_pkg::PEND_NONE;
               open_record(csas_pkg::REC_SESSION, csas_pkg::PH_SEND_SESSION);
               outcome.accepted = 1'b1;
               sessions_opened++;
            end
         end
         csas_pkg::OP_CANCEL: begin
            if (sess.phase != csas_pkg::PH_IDLE) begin
               sess.cancel_flag = 1'b1;
               if (sess.phase == csas_pkg::PH_CAP_TIMING ||
                   sess.phase == csas_pkg::PH_CAP_RAW) begin
                  outcome.halt_capture = 1'b1;
                  open_record(csas_pkg::REC_COMPLETE, csas_pkg::PH_SEND_COMPLETE);
               end else if (sess.phase == csas_pkg::PH_WAIT)
                  open_record(csas_pkg::REC_COMPLETE, csas_pkg::PH_SEND_COMPLETE);
               else if (sess.phase == csas_pkg::PH_DRAIN)
                  sess.pending = csas_pkg::PEND_ADVANCE;
            end
         end
         csas_pkg::OP_ACK: begin
            if (ev.ack_sequence == sess.sequence_num && acked_record) begin
               if (sess.phase == csas_pkg::PH_DRAIN) begin
                  // held until the drain is over
                  if (ev.ack_retry) sess.pending = csas_pkg::PEND_RETRY;
                  else sess.pending = csas_pkg::PEND_ADVANCE;
                  outcome.accepted = 1'b1;
               end else if (sess.phase == csas_pkg::PH_WAIT) begin
                  host_reply(ev.ack_retry);
                  outcome.accepted = 1'b1;
               end
            end
         end
         csas_pkg::OP_SERVICE: begin
            if (sess.phase != csas_pkg::PH_IDLE) begin
               if (!ev.link_up)
                  halt_session();
               else if (sess.phase == csas_pkg::PH_DRAIN) begin
                  waited = ev.now_us - sess.drain_start;  // wraps mod 2^32
                  if (waited >= limits.drain_time_us) begin
                     if (acked_record) begin
                        sess.phase = csas_pkg::PH_WAIT;
                        if (sess.pending != csas_pkg::PEND_NONE) begin
                           retry_now    = (sess.pending == csas_pkg::PEND_RETRY);
                           sess.pending = csas_pkg::PEND_NONE;
                           host_reply(retry_now);
                        end
                     end else
                        close_record(sess.drained_phase);
                  end
               end else begin
                  if (sess.phase == csas_pkg::PH_CAP_TIMING && ev.capture_done) begin
                     outcome.halt_capture = 1'b1;
                     open_record(csas_pkg::REC_TIMING, csas_pkg::PH_SEND_TIMING);
                  end else if (sess.phase == csas_pkg::PH_CAP_RAW && ev.capture_done) begin
                     outcome.halt_capture = 1'b1;
                     open_record(csas_pkg::REC_RAW, csas_pkg::PH_SEND_RAW);
                  end
                  // a record begun just above may finish sending in the same beat
                  if (sess.phase >= csas_pkg::PH_SEND_SESSION &&
                      sess.phase <= csas_pkg::PH_SEND_COMPLETE && ev.send_done) begin
                     sess.drained_phase = sess.phase;
                     sess.drain_start   = ev.now_us;
                     sess.phase         = csas_pkg::PH_DRAIN;
                  end
               end
            end
         end
         csas_pkg::OP_STOP: halt_session();
         default: ;
      endcase
      outcome.phase         = sess.phase;
      outcome.sequence_now  = sess.sequence_num;
      outcome.repeat_now    = sess.repeat_index;
      outcome.was_cancelled = sess.cancel_flag;
      outcome.session_tag   = sess.session;
      return outcome;
   endfunction

   // ---------------------------------------------------------------------
   // Event construction
   // ---------------------------------------------------------------------
   function automatic csas_pkg::req_type plain_event(input logic [csas_pkg::OP_W-1:0] op);
      csas_pkg::req_type ev;
      ev         = '0;
      ev.op      = op;
      ev.link_up = 1'b1;
      return ev;
   endfunction

   function automatic csas_pkg::req_type start_event(
      input logic [csas_pkg::LINE_W-1:0] line,
      input logic [csas_pkg::LINE_W-1:0] lines,
      input logic [csas_pkg::REP_W-1:0]  reps);
      csas_pkg::req_type ev;
      ev                = plain_event(csas_pkg::OP_START);
      ev.first_line     = line;
      ev.lines_wanted   = lines;
      ev.repeats_wanted = reps;
      return ev;
   endfunction

   // Mostly the next event a healthy session would see, with random payload;
   // a small share of pure noise (unused codes, link loss, stray stops).
   function automatic csas_pkg::req_type pick_event();
      logic [127:0] noise;
      csas_pkg::req_type ev;
      int unsigned roll;
      int unsigned reps_cap;
      noise = {$urandom(), $urandom(), $urandom(), $urandom()};
      ev    = noise[$bits(csas_pkg::req_type)-1:0];
      roll  = $urandom_range(0, 99);
      if (roll < 7) return ev;
      ev.link_up = 1'b1;
      roll = $urandom_range(0, 99);
      case (sess.phase)
         csas_pkg::PH_IDLE: begin
            ev.op             = csas_pkg::OP_START;
            ev.engine_blocked = (roll < 5);
            if (limits.min_start_line <= limits.max_start_line)
               ev.first_line = csas_pkg::LINE_W'($urandom_range(limits.min_start_line,
                                                                limits.max_start_line));
            ev.lines_wanted = csas_pkg::LINE_W'($urandom_range(1, limits.max_line_count));
            reps_cap = (limits.max_repeat_count > 4) ? 4 : limits.max_repeat_count;
            if (roll >= 95) reps_cap = limits.max_repeat_count;
            ev.repeats_wanted = csas_pkg::REP_W'($urandom_range(1, reps_cap));
         end
         csas_pkg::PH_SEND_SESSION, csas_pkg::PH_SEND_TIMING, csas_pkg::PH_SEND_RAW,
         csas_pkg::PH_SEND_COMPLETE: begin
            ev.op        = (roll < 8) ? csas_pkg::OP_CANCEL : csas_pkg::OP_SERVICE;
            ev.send_done = (roll < 85);
         end
         csas_pkg::PH_CAP_TIMING, csas_pkg::PH_CAP_RAW: begin
            ev.op = (roll < 6) ? csas_pkg::OP_CANCEL :
                    (roll < 12) ? csas_pkg::OP_ACK : csas_pkg::OP_SERVICE;
            ev.capture_done = (roll < 85);
         end
         csas_pkg::PH_DRAIN: begin
            if (roll < 15) begin
               ev.op           = csas_pkg::OP_ACK;
               ev.ack_sequence = sess.sequence_num;
               ev.ack_retry    = ($urandom_range(0, 99) < 30);
            end else if (roll < 21)
               ev.op = csas_pkg::OP_CANCEL;
            else begin
               // land on, just past or just short of the drain deadline
               ev.op     = csas_pkg::OP_SERVICE;
               ev.now_us = sess.drain_start + limits.drain_time_us + $urandom_range(0, 40);
               if ($urandom_range(0, 99) < 25)
                  ev.now_us = sess.drain_start + limits.drain_time_us - $urandom_range(1, 3);
            end
         end
         csas_pkg::PH_WAIT: begin
            if (roll < 10)
               ev.op = csas_pkg::OP_CANCEL;
            else begin
               ev.op           = csas_pkg::OP_ACK;
               ev.ack_sequence = sess.sequence_num;
               if (roll < 16) ev.ack_sequence = ev.ack_sequence + $urandom_range(1, 2);
               ev.ack_retry = ($urandom_range(0, 99) < 25);
            end
         end
         default: ;
      endcase
      return ev;
   endfunction

   // ---------------------------------------------------------------------
   // Event channel driver. valid stays high after a beat; it drops only in
   // an idle cycle or when the caller pauses (wait_drained).
   // ---------------------------------------------------------------------
   task automatic send_event(input csas_pkg::req_type ev);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.op             <= ev.op;
      req_chan.first_line     <= ev.first_line;
      req_chan.lines_wanted   <= ev.lines_wanted;
      req_chan.repeats_wanted <= ev.repeats_wanted;
      req_chan.engine_blocked <= ev.engine_blocked;
      req_chan.ack_sequence   <= ev.ack_sequence;
      req_chan.ack_retry      <= ev.ack_retry;
      req_chan.link_up        <= ev.link_up;
      req_chan.capture_done   <= ev.capture_done;
      req_chan.send_done      <= ev.send_done;
      req_chan.now_us         <= ev.now_us;
      do @(posedge clock); while (!req_chan.ready);
      // beat taken at this edge
      report_q.push_back(apply_event(ev));
      events_sent++;
   endtask

   task automatic run_traffic(input int count);
      for (int i = 0; i < count; i++) send_event(pick_event());
   endtask

   // Stop offering and let every predicted report come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (report_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csas_pkg::csr_idx_type idx,
                            input logic [csas_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Only called with nothing in flight.
   task automatic program_limits(input csas_pkg::cfg_type c);
      write_reg(csas_pkg::CSR_MIN_START_LINE,   csas_pkg::CSR_DATA_W'(c.min_start_line));
      write_reg(csas_pkg::CSR_MAX_START_LINE,   csas_pkg::CSR_DATA_W'(c.max_start_line));
      write_reg(csas_pkg::CSR_MAX_LINE_COUNT,   csas_pkg::CSR_DATA_W'(c.max_line_count));
      write_reg(csas_pkg::CSR_MAX_REPEAT_COUNT, csas_pkg::CSR_DATA_W'(c.max_repeat_count));
      write_reg(csas_pkg::CSR_DRAIN_TIME_US,    c.drain_time_us);
      csr_we <= 1'b0;
      limits = c;
   endtask

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct <= rx_pct;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset limits: odd codes, rejects, one cancelled session through its
   // drains (including a wrapped clock), then link loss and a bare stop.
   task automatic test_corner_events();
      csas_pkg::req_type ev;
      send_event(plain_event(OP_UNUSED_LO));
      ev    = '1;
      ev.op = OP_UNUSED_HI;
      send_event(ev);
      send_event(plain_event(csas_pkg::OP_SERVICE));         // service in idle
      send_event(plain_event(csas_pkg::OP_CANCEL));          // cancel in idle
      send_event(plain_event(csas_pkg::OP_ACK));             // ack with no drained record
      ev = start_event(10'd100, 10'd8, 16'd2);
      ev.engine_blocked = 1'b1;
      send_event(ev);
      send_event(start_event(10'd0,   10'd8,  16'd2));       // line below window
      send_event(start_event(10'd313, 10'd8,  16'd2));       // line above window
      send_event(start_event(10'd100, 10'd0,  16'd2));       // zero lines
      send_event(start_event(10'd100, 10'd65, 16'd2));       // too many lines
      send_event(start_event(10'd100, 10'd8,  16'd0));       // zero repeats
      send_event(start_event(10'd100, 10'd8,  16'hFFFF));    // too many repeats
      ev = start_event(10'd312, 10'd64, 16'd16);
      ev.now_us = 32'hFFFF_FFF0;
      send_event(ev);                                        // all at the upper limits
      send_event(start_event(10'd100, 10'd8, 16'd2));        // busy
      send_event(plain_event(csas_pkg::OP_CANCEL));          // while sending: flag only
      ev = plain_event(csas_pkg::OP_SERVICE);
      ev.send_done = 1'b1;
      ev.now_us    = '1;
      send_event(ev);
      ev.send_done = 1'b0;
      ev.now_us    = 32'd9998;                               // one short, across the wrap
      send_event(ev);
      ev.now_us    = 32'd9999;                               // exactly the drain time
      send_event(ev);
      ev.send_done = 1'b1;
      ev.now_us    = 32'd0;
      send_event(ev);
      ev.send_done = 1'b0;
      ev.now_us    = 32'd10000;
      send_event(ev);
      send_event(start_event(10'd1, 10'd1, 16'd1));          // lower limits
      ev = plain_event(csas_pkg::OP_SERVICE);
      ev.link_up = 1'b0;                                     // link loss acts as stop
      send_event(ev);
      send_event(plain_event(csas_pkg::OP_STOP));
   endtask

   task automatic test_narrow_limits();
      wait_drained();
      program_limits('{min_start_line: 10'd5, max_start_line: 10'd20,
                       max_line_count: 10'd8, max_repeat_count: 16'd3,
                       drain_time_us: 20'd7});
      run_traffic(400);
   endtask

   task automatic test_wide_limits();
      wait_drained();
      set_idling(82, 26);
      program_limits('{min_start_line: 10'd0, max_start_line: 10'd1023,
                       max_line_count: 10'd1023, max_repeat_count: 16'd65535,
                       drain_time_us: 20'd1000000});
      run_traffic(400);
   endtask

   // One-point start window and no drain wait.
   task automatic test_closed_window();
      wait_drained();
      set_idling(0, 0);
      program_limits('{min_start_line: 10'd1023, max_start_line: 10'd1023,
                       max_line_count: 10'd1, max_repeat_count: 16'd1,
                       drain_time_us: 20'd0});
      run_traffic(250);
   endtask

   // Receiver holds off while beats keep coming, so the core backs up and
   // drops req ready; then the sender waits for every report.
   task automatic test_backpressure();
      hold_asked <= hold_asked + 1;
      run_traffic(40);
      wait_drained();
   endtask

   task automatic test_default_limits();
      wait_drained();
      program_limits(csas_pkg::CFG_RST);
      run_traffic(330);
   endtask

   // ---------------------------------------------------------------------
   // Report channel: random ready, plus the long hold-off on request.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served    <= hold_asked;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else
         rsp_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Each report beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_checked++;
         if (report_q.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("report beat %0d with none expected (phase %0d seq %0h)",
                        results_checked, rsp_chan.phase, rsp_chan.sequence_now);
         end else begin
            due = report_q.pop_front();
            if (rsp_chan.accepted       !== due.accepted       ||
                rsp_chan.phase          !== due.phase          ||
                rsp_chan.record_started !== due.record_started ||
                rsp_chan.arm_command    !== due.arm_command    ||
                rsp_chan.halt_capture   !== due.halt_capture   ||
                rsp_chan.resend         !== due.resend         ||
                rsp_chan.sequence_now   !== due.sequence_now   ||
                rsp_chan.repeat_now     !== due.repeat_now     ||
                rsp_chan.was_cancelled  !== due.was_cancelled  ||
                rsp_chan.session_tag    !== due.session_tag) begin
               faults++;
               if (faults <= 10) begin
                  $display("report %0d mismatch, want acc %0d ph %0d rec %0d arm %0d halt %0d",
                           results_checked, due.accepted, due.phase, due.record_started,
                           due.arm_command, due.halt_capture);
                  $display("   resend %0d seq %0h rep %0d cxl %0d tag %0h",
                           due.resend, due.sequence_now, due.repeat_now,
                           due.was_cancelled, due.session_tag);
                  $display("   got acc %0d ph %0d rec %0d arm %0d halt %0d",
                           rsp_chan.accepted, rsp_chan.phase, rsp_chan.record_started,
                           rsp_chan.arm_command, rsp_chan.halt_capture);
                  $display("   resend %0d seq %0h rep %0d cxl %0d tag %0h",
                           rsp_chan.resend, rsp_chan.sequence_now, rsp_chan.repeat_now,
                           rsp_chan.was_cancelled, rsp_chan.session_tag);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d reports outstanding",
                  cycle_count, report_q.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= csas_pkg::CSR_MIN_START_LINE;
      csr_wdata               <= '0;
      req_chan.valid          <= 1'b0;
      req_chan.op             <= csas_pkg::OP_START;
      req_chan.first_line     <= '0;
      req_chan.lines_wanted   <= '0;
      req_chan.repeats_wanted <= '0;
      req_chan.engine_blocked <= 1'b0;
      req_chan.ack_sequence   <= '0;
      req_chan.ack_retry      <= 1'b0;
      req_chan.link_up        <= 1'b0;
      req_chan.capture_done   <= 1'b0;
      req_chan.send_done      <= 1'b0;
      req_chan.now_us         <= '0;
      hold_asked              <= 0;
      faults          = 0;
      events_sent     = 0;
      results_checked = 0;
      sessions_opened = 0;
      resends_seen    = 0;
      sess   = csas_pkg::STATE_RST;
      limits = csas_pkg::CFG_RST;
      set_idling(26, 82);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_corner_events();
      test_narrow_limits();
      test_wide_limits();
      test_closed_window();
      test_backpressure();
      test_default_limits();

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("%0d event beats, %0d reports checked, %0d sessions opened, %0d resends,",
               events_sent, results_checked, sessions_opened, resends_seen);
      $display("four limit settings, both idling splits and a long report hold-off");
      if (faults == 0 && report_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/csas_pkg.sv
hw/rtl/csas_req_if.sv
hw/rtl/csas_rsp_if.sv
hw/rtl/csas_step.sv
hw/rtl/capture_session_ack_sequencer_core.sv
verif/tb_capture_session_ack_sequencer_core.sv
